>>> src/wttt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Wake-time task table package
// Shared types, operation and status codes for the task table unit.
// ---------------------------------------------------------------------------
package wttt_pkg;

   localparam int DEFAULT_SLOTS = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int FOUND_W       = $clog2(MAX_RESULTS);

   localparam logic [2:0] OP_REGISTER = 3'd0;
   localparam logic [2:0] OP_CANCEL   = 3'd1;
   localparam logic [2:0] OP_PROCESS  = 3'd2;
   localparam logic [2:0] OP_REPORT   = 3'd3;
   localparam logic [2:0] OP_TIMEOUT  = 3'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  slot_id;
      logic [31:0] now_time;
      logic        keep_running;
      logic [31:0] wake_delay;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  task_slot;
      logic        is_due;
      logic [31:0] timeout;
      logic [4:0]  live_count;
      logic        last;
   } rsp_type;

   // Slot store commands issued by the sequencer.
   typedef struct packed {
      logic set_active;
      logic clr_active;
      logic wr_wake;
   } store_cmd_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        sub;
   } alu_op_type;

   typedef struct packed {
      logic [31:0] sum;
      logic        neg;
   } alu_res_type;

endpackage
`default_nettype wire

>>> src/wake_time_task_table_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Wake-time task table unit
// Slot table of a cooperative scheduler: register, cancel, process due,
// report status and next timeout, run by a sequencer around one shared
// 32-bit adder/subtractor and a wake-time memory.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------
//   req     | in        | req_valid / req_ready | req_data (req_type)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data (rsp_type)
//
// Register, process due and next timeout walk the slots one per cycle
// through the memory read port (process due can pause for the output);
// cancel and report pass through ST_APPLY, an unknown opcode does not.
// Reset is synchronous and clears every slot flag and the count at once.
// A stalled response transfer holds the walk only when a process result is
// waiting to leave; the request side is ready whenever the sequencer idles.
// ---------------------------------------------------------------------------
module wake_time_task_table_unit #(
   parameter int SLOTS = wttt_pkg::DEFAULT_SLOTS
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wttt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output wttt_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Sequencer registers and their next values.
   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [2:0]                op_ff, op_in;
   logic [3:0]                id_ff, id_in;
   logic [31:0]               now_ff, now_in;
   logic                      keep_ff, keep_in;
   logic [31:0]               delay_ff, delay_in;
   logic [31:0]               best_ff, best_in;
   logic [wttt_pkg::FOUND_W-1:0] found_ff, found_in;
   wttt_pkg::rsp_type         hold_ff, hold_in;
   logic                      hold_valid_ff, hold_valid_in;
   wttt_pkg::rsp_type         rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Store and arithmetic connections.
   wttt_pkg::store_cmd_type   cmd;
   logic [IDX_W-1:0]          wr_addr;
   logic [31:0]               wr_data;
   logic [IDX_W-1:0]          rd_addr;
   logic [31:0]               rd_wake;
   logic                      rd_active;
   logic [CNT_W-1:0]          count;
   wttt_pkg::alu_op_type      alu_op;
   wttt_pkg::alu_res_type     alu_res;

   logic                      out_free;
   logic                      last_idx;
   logic                      req_id_ok;
   logic                      id_ok;
   logic                      slot_due;
   logic [31:0]               remain;
   logic [31:0]               best_next;
   logic                      scan_done;

   wttt_slot_store #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_wake   (rd_wake),
      .rd_active (rd_active),
      .count     (count)
   );

   wttt_time_alu u_alu (
      .alu_op  (alu_op),
      .alu_res (alu_res)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The output register can take a new result when empty or draining.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_idx  = (32'(idx_ff) == SLOTS - 1);
   assign req_id_ok = (32'(req_data.slot_id) < SLOTS);
   assign id_ok     = (32'(id_ff) < SLOTS);

   // During a walk the read data belongs to the slot at idx_ff. A slot is
   // due when now minus its wake time is non-negative as a signed value;
   // the remaining delay is wake minus now, clamped at zero.
   assign slot_due  = rd_active && !alu_res.neg;
   assign remain    = alu_res.neg ? 32'd0 : alu_res.sum;
   assign best_next = (rd_active && (remain < best_ff)) ? remain : best_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      now_in        = now_ff;
      keep_in       = keep_ff;
      delay_in      = delay_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd           = '0;
      wr_addr       = idx_ff;
      wr_data       = 32'd0;
      rd_addr       = idx_ff;
      scan_done     = 1'b0;
      alu_op.a      = now_ff;
      alu_op.b      = rd_wake;
      alu_op.sub    = 1'b1;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_data.opcode;
               id_in         = req_data.slot_id;
               now_in        = req_data.now_time;
               keep_in       = req_data.keep_running;
               delay_in      = req_data.wake_delay;
               idx_in        = '0;
               best_in       = '1;
               found_in      = '0;
               hold_valid_in = 1'b0;
               hold_in       = '0;
               rd_addr       = '0;
               case (req_data.opcode) inside
                  wttt_pkg::OP_REGISTER, wttt_pkg::OP_PROCESS,
                  wttt_pkg::OP_TIMEOUT: begin
                     state_in = ST_SCAN;
                  end
                  wttt_pkg::OP_CANCEL, wttt_pkg::OP_REPORT: begin
                     // Fetch the addressed slot for the check in the next cycle.
                     rd_addr  = req_id_ok ? IDX_W'(req_data.slot_id) : '0;
                     state_in = ST_APPLY;
                  end
                  default: begin
                     hold_in.status = wttt_pkg::STATUS_IGNORED;
                     state_in       = ST_FINISH;
                  end
               endcase
            end
         end

         ST_APPLY: begin
            // The shared unit forms now plus delay for a reschedule.
            alu_op.a          = now_ff;
            alu_op.b          = delay_ff;
            alu_op.sub        = 1'b0;
            wr_addr           = IDX_W'(id_ff);
            wr_data           = alu_res.sum;
            hold_in           = '0;
            hold_in.task_slot = id_ff;
            if (id_ok && rd_active) begin
               hold_in.status = wttt_pkg::STATUS_OK;
               if ((op_ff == wttt_pkg::OP_REPORT) && keep_ff) begin
                  cmd.wr_wake = 1'b1;
               end else begin
                  cmd.clr_active = 1'b1;
               end
            end else begin
               hold_in.status = wttt_pkg::STATUS_IGNORED;
            end
            state_in = ST_FINISH;
         end

         ST_SCAN: begin
            case (op_ff)
               wttt_pkg::OP_REGISTER: begin
                  if (!rd_active) begin
                     cmd.set_active    = 1'b1;
                     cmd.wr_wake       = 1'b1;
                     hold_in           = '0;
                     hold_in.status    = wttt_pkg::STATUS_OK;
                     hold_in.task_slot = 4'(idx_ff);
                     state_in          = ST_FINISH;
                  end else if (last_idx) begin
                     hold_in        = '0;
                     hold_in.status = wttt_pkg::STATUS_FULL;
                     state_in       = ST_FINISH;
                  end else begin
                     idx_in  = idx_ff + IDX_W'(1);
                     rd_addr = idx_ff + IDX_W'(1);
                  end
               end

               wttt_pkg::OP_TIMEOUT: begin
                  alu_op.a   = rd_wake;
                  alu_op.b   = now_ff;
                  alu_op.sub = 1'b1;
                  best_in    = best_next;
                  if (last_idx) begin
                     hold_in         = '0;
                     hold_in.status  = wttt_pkg::STATUS_OK;
                     hold_in.timeout = best_next;
                     state_in        = ST_FINISH;
                  end else begin
                     idx_in  = idx_ff + IDX_W'(1);
                     rd_addr = idx_ff + IDX_W'(1);
                  end
               end

               default: begin
                  // Process due. The most recent due slot is held back so
                  // that the final one can carry the last marker.
                  if (!(slot_due && hold_valid_ff && !out_free)) begin
                     if (slot_due) begin
                        if (hold_valid_ff) begin
                           rsp_in            = hold_ff;
                           rsp_in.live_count = 5'(count);
                           rsp_in.last       = 1'b0;
                           rsp_valid_in      = 1'b1;
                        end
                        hold_in           = '0;
                        hold_in.status    = wttt_pkg::STATUS_OK;
                        hold_in.task_slot = 4'(idx_ff);
                        hold_in.is_due    = 1'b1;
                        hold_valid_in     = 1'b1;
                        found_in          = found_ff + wttt_pkg::FOUND_W'(1);
                     end
                     scan_done = last_idx ||
                                 (slot_due && (32'(found_ff) == wttt_pkg::MAX_RESULTS - 1));
                     if (scan_done) begin
                        if (!slot_due && !hold_valid_ff) begin
                           hold_in        = '0;
                           hold_in.status = wttt_pkg::STATUS_OK;
                        end
                        state_in = ST_FINISH;
                     end else begin
                        idx_in  = idx_ff + IDX_W'(1);
                        rd_addr = idx_ff + IDX_W'(1);
                     end
                  end
               end
            endcase
         end

         ST_FINISH: begin
            // The count already reflects this operation's update.
            if (out_free) begin
               rsp_in            = hold_ff;
               rsp_in.live_count = 5'(count);
               rsp_in.last       = 1'b1;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff   <= idx_in;
      op_ff    <= op_in;
      id_ff    <= id_in;
      now_ff   <= now_in;
      keep_ff  <= keep_in;
      delay_ff <= delay_in;
      best_ff  <= best_in;
      found_ff <= found_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

endmodule
`default_nettype wire

>>> src/wttt_time_alu.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Wake-time adder/subtractor
// The one shared 32-bit add or subtract unit, modulo 2^32, with sign flag.
// ---------------------------------------------------------------------------
module wttt_time_alu (
   input  wttt_pkg::alu_op_type  alu_op,
   output wttt_pkg::alu_res_type alu_res
);

   logic [31:0] operand_b;

   assign operand_b   = alu_op.sub ? ~alu_op.b : alu_op.b;
   assign alu_res.sum = alu_op.a + operand_b + {31'd0, alu_op.sub};
   assign alu_res.neg = alu_res.sum[31];

endmodule
`default_nettype wire

>>> src/wttt_slot_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Wake-time slot store
// Active flags, active-slot count and the wake-time memory with a
// registered read port.
// ---------------------------------------------------------------------------
module wttt_slot_store #(
   parameter int SLOTS = wttt_pkg::DEFAULT_SLOTS,
   parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   parameter int CNT_W = $clog2(SLOTS + 1)
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wttt_pkg::store_cmd_type cmd,
   input  wire  [IDX_W-1:0]        wr_addr,
   input  wire  [31:0]             wr_data,
   input  wire  [IDX_W-1:0]        rd_addr,
   output logic [31:0]             rd_wake,
   output logic                    rd_active,
   output logic [CNT_W-1:0]        count
);

   logic [SLOTS-1:0] active_ff;
   logic [CNT_W-1:0] count_ff;
   logic [31:0]      wake_mem [SLOTS];
   logic [31:0]      rd_wake_ff;
   logic             rd_active_ff;

   // The wake time is only read for active slots, and claiming a slot
   // always writes it, so the memory itself needs no clearing.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (cmd.set_active) begin
            active_ff[wr_addr] <= 1'b1;
            count_ff           <= count_ff + CNT_W'(1);
         end else if (cmd.clr_active) begin
            active_ff[wr_addr] <= 1'b0;
            count_ff           <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_wake) begin
         wake_mem[wr_addr] <= wr_data;
      end
      rd_wake_ff   <= wake_mem[rd_addr];
      rd_active_ff <= active_ff[rd_addr];
   end

   assign rd_wake   = rd_wake_ff;
   assign rd_active = rd_active_ff;
   assign count     = count_ff;

endmodule
`default_nettype wire
